### rtl/core/dcbd_pkg.sv
// ----------------------------------------------------------------------------
// Detection cell box decode package
// Widths, register indexes, fixed-point constants and the sequencer states
// shared by the interfaces and the decoder.
// ----------------------------------------------------------------------------
package dcbd_pkg;

  localparam int GRID_SIZE_DEF   = 22;
  localparam int NUM_CLASSES_DEF = 80;

  localparam int VAL_W     = 16;
  localparam int CH_W      = 7;
  localparam int GRID_W    = 6;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CORNER_W  = 14;
  localparam int SCORE_W   = 13;

  localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 2'd2;

  localparam logic [CFG_W-1:0] THRESHOLD_RST    = 13'd2048;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [31:0] ONE_Q30   = 32'h4000_0000;

  // 2^25 / 5 rounded up; exact for magnitudes below 2^23.
  localparam logic [31:0] RECIP5 = 32'd6710887;

  // 2^(2^-(j+1)) in Q30.
  function automatic logic [31:0] pow2_frac(input logic [2:0] j);
    logic [31:0] r;
    unique case (j)
      3'd0: r = 32'd1518500250;
      3'd1: r = 32'd1276901417;
      3'd2: r = 32'd1170923762;
      3'd3: r = 32'd1121280436;
      3'd4: r = 32'd1097253708;
      3'd5: r = 32'd1085434106;
      3'd6: r = 32'd1079572136;
      3'd7: r = 32'd1076653033;
    endcase
    return r;
  endfunction

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOG_INIT,
    S_LOG_MUL,
    S_LOG_STEP,
    S_DIV5_MUL,
    S_DIV5_STEP,
    S_EXP_INIT,
    S_EXP_LN,
    S_EXP_LIN,
    S_EXP_TAB,
    S_EXP_TABU,
    S_EXP_FIN,
    S_SCORE,
    S_FN_INIT,
    S_FN_E,
    S_DIV_SETUP,
    S_DIV,
    S_CRN_INIT,
    S_CRN_M1,
    S_CRN_M2,
    S_CRN_Q,
    S_EMIT
  } state_t;

endpackage

### rtl/core/dcbd_in_if.sv
// ----------------------------------------------------------------------------
// Detection cell box decode input channel
// One tensor value with its channel and grid cell tags, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dcbd_in_if import dcbd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] channel_value;
  logic [CH_W-1:0]         channel_index;
  logic [GRID_W-1:0]       grid_row;
  logic [GRID_W-1:0]       grid_col;

  modport source(output valid, channel_value, channel_index, grid_row, grid_col,
                 input ready);
  modport sink(input valid, channel_value, channel_index, grid_row, grid_col,
               output ready);
endinterface

### rtl/core/dcbd_out_if.sv
// ----------------------------------------------------------------------------
// Detection cell box decode output channel
// One decoded box with score and class, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dcbd_out_if import dcbd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [CORNER_W-1:0] left_x;
  logic signed [CORNER_W-1:0] top_y;
  logic signed [CORNER_W-1:0] right_x;
  logic signed [CORNER_W-1:0] bottom_y;
  logic [SCORE_W-1:0]         detection_score;
  logic [CH_W-1:0]            class_id;

  modport source(output valid, left_x, top_y, right_x, bottom_y, detection_score, class_id,
                 input ready);
  modport sink(input valid, left_x, top_y, right_x, bottom_y, detection_score, class_id,
               output ready);
endinterface

### rtl/core/detection_cell_box_decode_top.sv
// ----------------------------------------------------------------------------
// Detection cell box decode, top level
// Collects a grid cell's channels and decodes a scored box on its last class.
// ----------------------------------------------------------------------------
// Every value is stored as it is accepted and the input stays ready for the
// next, except a cell's last class channel when both objectness and the best
// class score are positive. That channel starts a sequencer around one shared
// 32x32 multiplier: two 16-step log2 squaring loops, a divide by five, a 2^x
// evaluation, then for a detection four more 2^x evaluations each followed by
// a 14-step restoring divide (tanh and sigmoid), and four corner scalings.
// That transfer holds the input off until the sequencer returns to idle,
// longer when a box is produced than when the cell is rejected on its score;
// the time varies with the number of set fraction bits in each 2^x exponent,
// and the multiplier's one product per cycle sets the pace. A finished box
// waits in an output register, so the values of later cells keep flowing
// while the previous box is still unclaimed; only a second finished box waits
// for the first to be taken.
module detection_cell_box_decode_top import dcbd_pkg::*; #(
  parameter int GRID_SIZE   = GRID_SIZE_DEF,
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  dcbd_in_if.sink              in_ch,
  dcbd_out_if.source           out_ch
);

  localparam logic [CH_W-1:0] FIRST_CLASS = 7'd5;
  localparam logic [CH_W-1:0] LAST_CH     = 7'(4 + NUM_CLASSES);
  localparam logic [6:0]      GRID_K      = 7'(GRID_SIZE);
  localparam logic [27:0]     RECIPG      = 28'(((64'd1 << 27) + 64'(GRID_SIZE) - 64'd1)
                                                / 64'(GRID_SIZE));

  state_t state, state_next;

  logic [CFG_W-1:0] score_threshold, frame_width, frame_height;

  logic signed [VAL_W-1:0] objectness, best_class_score;
  logic signed [VAL_W-1:0] box_raw [4];
  logic [CH_W-1:0]         best_class_index;
  logic [GRID_W-1:0]       cell_row, cell_col;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic [31:0]        mant;
  logic [15:0]        frac;
  logic [3:0]         lead;
  logic [3:0]         step_cnt;
  logic               phase;
  logic signed [23:0] log_acc;
  logic signed [23:0] ex;
  logic               zero_exp;
  logic [15:0]        ef;
  logic signed [7:0]  en;
  logic [3:0]         tab_j;
  logic [31:0]        lin;
  logic               fn_mode;
  logic [1:0]         fi;
  logic [12:0]        score;
  logic signed [13:0] tx, ty;
  logic [12:0]        sw, sh;
  logic [43:0]        rem;
  logic [56:0]        dd;
  logic [13:0]        quo;
  logic [1:0]         ci;
  logic [20:0]        nmag;
  logic               nneg;
  logic signed [13:0] crn [4];
  logic               res_valid;

  // Input side decode
  logic               in_fire, is_last, start;
  logic [CH_W-1:0]    class_k;
  logic               take_best;
  logic signed [VAL_W-1:0] best_new;

  always_comb begin
    in_fire   = in_ch.valid && in_ch.ready;
    class_k   = in_ch.channel_index - FIRST_CLASS;
    is_last   = (in_ch.channel_index == LAST_CH);
    take_best = (class_k == 7'd0) || (in_ch.channel_value > best_class_score);
    best_new  = take_best ? in_ch.channel_value : best_class_score;
    start     = in_fire && is_last && (objectness > 16'sd0) && (best_new > 16'sd0);
  end

  // Datapath helpers
  logic [14:0]        log_x;
  logic [3:0]         lead_c;
  logic [31:0]        sq;
  logic [15:0]        frac_new;
  logic signed [20:0] lval;
  logic signed [23:0] lext;
  logic [23:0]        acc_mag;
  logic [22:0]        q5;
  logic signed [24:0] bsum, bcl;
  logic [7:0]         nsh;
  logic [12:0]        score_t, score_c;
  logic signed [VAL_W-1:0] fn_v;
  logic [16:0]        fn_mag;
  logic [22:0]        fq;
  logic [61:0]        xw, dw;
  logic               div_ge;
  logic [13:0]        quo_new;
  logic [GRID_W-1:0]  cg;
  logic signed [13:0] ct;
  logic [12:0]        cs;
  logic signed [22:0] num;
  logic [21:0]        cq;
  logic signed [13:0] crn_c;

  always_comb begin
    log_x  = phase ? best_class_score[14:0] : objectness[14:0];
    lead_c = 4'd0;
    for (int i = 0; i < 15; i++) begin
      if (log_x[i]) begin
        lead_c = 4'(i);
      end
    end

    sq       = mul_p[61:30];
    frac_new = frac;
    if (sq[31]) begin
      frac_new[step_cnt] = 1'b1;
    end
    lval    = $signed({5'(lead) - 5'd12, frac_new});
    lext    = {{3{lval[20]}}, lval};
    acc_mag = log_acc[23] ? 24'(-log_acc) : log_acc;
    q5      = mul_p[47:25];

    bsum = $signed({ex[23], ex}) + 25'sd4194304;
    bcl  = (bsum > 25'sd6160384) ? 25'sd6160384 : bsum;

    // Score is the Q30 power taken down to Q12; it saturates above one.
    nsh     = 8'(-en);
    score_t = (nsh >= 8'd13) ? 13'd0 : (mant[30:18] >> nsh[3:0]);
    if (zero_exp) begin
      score_c = 13'd0;
    end else if (en > 8'sd0) begin
      score_c = 13'd4096;
    end else if (score_t > 13'd4096) begin
      score_c = 13'd4096;
    end else begin
      score_c = score_t;
    end

    fn_v   = box_raw[fi];
    fn_mag = fn_v[15] ? 17'(-{fn_v[15], fn_v}) : {1'b0, fn_v};
    fq     = mul_p[34:12];

    if (zero_exp) begin
      xw = 62'd0;
    end else if (!en[7]) begin
      xw = {30'd0, mant} << en[4:0];
    end else if (nsh >= 8'd63) begin
      xw = 62'd0;
    end else begin
      xw = {30'd0, mant} >> nsh[5:0];
    end
    dw = {30'd0, ONE_Q30} + xw;

    div_ge  = (dd <= {13'd0, rem});
    quo_new = quo | (div_ge ? (14'd1 << step_cnt) : 14'd0);

    cg  = ci[0] ? cell_row : cell_col;
    ct  = ci[0] ? ty : tx;
    cs  = ci[0] ? sh : sw;
    num = $signed({4'b0000, cg, 13'd0}) + (23'(ct) <<< 1);
    if (ci[1]) begin
      num = num + $signed({3'b000, 20'(GRID_K * cs)});
    end else begin
      num = num - $signed({3'b000, 20'(GRID_K * cs)});
    end

    cq = mul_p[48:27];
    if (nneg) begin
      crn_c = (cq > 22'd8192) ? -14'sd8192 : 14'(-$signed({1'b0, cq}));
    end else begin
      crn_c = (cq > 22'd8191) ? 14'sd8191 : $signed(cq[13:0]);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (start) state_next = S_LOG_INIT;
      S_LOG_INIT:  state_next = S_LOG_MUL;
      S_LOG_MUL:   state_next = S_LOG_STEP;
      S_LOG_STEP: begin
        if (step_cnt != 4'd0) begin
          state_next = S_LOG_MUL;
        end else begin
          state_next = phase ? S_DIV5_MUL : S_LOG_INIT;
        end
      end
      S_DIV5_MUL:  state_next = S_DIV5_STEP;
      S_DIV5_STEP: state_next = S_EXP_INIT;
      S_EXP_INIT:  state_next = S_EXP_LN;
      S_EXP_LN:    state_next = S_EXP_LIN;
      S_EXP_LIN:   state_next = S_EXP_TAB;
      S_EXP_TAB: begin
        if (tab_j[3]) begin
          state_next = S_EXP_FIN;
        end else if (ef[4'd15 - tab_j]) begin
          state_next = S_EXP_TABU;
        end
      end
      S_EXP_TABU:  state_next = S_EXP_TAB;
      S_EXP_FIN:   state_next = fn_mode ? S_DIV_SETUP : S_SCORE;
      S_SCORE:     state_next = (score_c > score_threshold) ? S_FN_INIT : S_IDLE;
      S_FN_INIT:   state_next = S_FN_E;
      S_FN_E:      state_next = S_EXP_INIT;
      S_DIV_SETUP: state_next = S_DIV;
      S_DIV: begin
        if (step_cnt == 4'd0) begin
          state_next = (fi == 2'd3) ? S_CRN_INIT : S_FN_INIT;
        end
      end
      S_CRN_INIT:  state_next = S_CRN_M1;
      S_CRN_M1:    state_next = S_CRN_M2;
      S_CRN_M2:    state_next = S_CRN_Q;
      S_CRN_Q:     state_next = (ci == 2'd3) ? S_EMIT : S_CRN_INIT;
      S_EMIT:      if (!res_valid || out_ch.ready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Multiplier operands and handshake
  always_comb begin
    mul_a       = 32'd0;
    mul_b       = 32'd0;
    in_ch.ready = (state == S_IDLE);
    unique case (state)
      S_LOG_MUL: begin
        mul_a = mant;
        mul_b = mant;
      end
      S_DIV5_MUL: begin
        mul_a = {8'd0, acc_mag};
        mul_b = RECIP5;
      end
      S_EXP_LN: begin
        mul_a = {24'd0, ef[7:0]};
        mul_b = {2'b00, LN2_Q30};
      end
      S_EXP_TAB: begin
        mul_a = mant;
        mul_b = tab_j[3] ? lin : pow2_frac(tab_j[2:0]);
      end
      S_FN_INIT: begin
        mul_a = {15'd0, fn_mag};
        mul_b = fi[1] ? {15'd0, LOG2E_Q16} : {14'd0, LOG2E_Q16, 1'b0};
      end
      S_CRN_M1: begin
        mul_a = {11'd0, nmag};
        mul_b = {19'd0, ci[0] ? frame_height : frame_width};
      end
      S_CRN_M2: begin
        mul_a = {11'd0, mul_p[33:13]};
        mul_b = {4'd0, RECIPG};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      score_threshold <= THRESHOLD_RST;
      frame_width     <= FRAME_WIDTH_RST;
      frame_height    <= FRAME_HEIGHT_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_SCORE_THRESHOLD: score_threshold <= cfg_data;
        REG_FRAME_WIDTH:     frame_width     <= cfg_data;
        REG_FRAME_HEIGHT:    frame_height    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Cell state
  always_ff @(posedge clk) begin
    if (rst) begin
      objectness       <= '0;
      best_class_score <= '0;
      best_class_index <= '0;
      for (int i = 0; i < 4; i++) begin
        box_raw[i] <= '0;
      end
    end else if (in_fire) begin
      if (in_ch.channel_index == 7'd0) begin
        objectness <= in_ch.channel_value;
      end else if (in_ch.channel_index < FIRST_CLASS) begin
        box_raw[2'(in_ch.channel_index - 7'd1)] <= in_ch.channel_value;
      end else if ((in_ch.channel_index <= LAST_CH) && take_best) begin
        best_class_score <= in_ch.channel_value;
        best_class_index <= class_k;
      end
    end
  end

  // Shared multiplier and sequencer datapath
  always_ff @(posedge clk) begin
    mul_p <= {32'd0, mul_a} * {32'd0, mul_b};
    unique case (state)
      S_IDLE: begin
        if (start) begin
          phase    <= 1'b0;
          log_acc  <= '0;
          cell_row <= in_ch.grid_row;
          cell_col <= in_ch.grid_col;
        end
      end
      S_LOG_INIT: begin
        lead     <= lead_c;
        mant     <= {17'd0, log_x} << (5'd30 - {1'b0, lead_c});
        frac     <= '0;
        step_cnt <= 4'd15;
      end
      S_LOG_STEP: begin
        mant     <= sq[31] ? {1'b0, sq[31:1]} : sq;
        frac     <= frac_new;
        step_cnt <= step_cnt - 4'd1;
        if (step_cnt == 4'd0) begin
          // Objectness is weighted by three fifths, the class by two fifths.
          log_acc <= phase ? log_acc + (lext <<< 1) : log_acc + lext + (lext <<< 1);
          phase   <= ~phase;
        end
      end
      S_DIV5_STEP: begin
        ex      <= log_acc[23] ? -$signed({1'b0, q5}) : $signed({1'b0, q5});
        fn_mode <= 1'b0;
      end
      S_EXP_INIT: begin
        zero_exp <= bsum[24];
        ef       <= bcl[15:0];
        en       <= $signed(8'(bcl[24:16]) - 8'd64);
        mant     <= ONE_Q30;
        tab_j    <= '0;
      end
      S_EXP_LIN: begin
        lin <= ONE_Q30 + {10'd0, mul_p[37:16]};
      end
      S_EXP_TAB: begin
        if (!tab_j[3] && !ef[4'd15 - tab_j]) begin
          tab_j <= tab_j + 4'd1;
        end
      end
      S_EXP_TABU: begin
        mant  <= mul_p[61:30];
        tab_j <= tab_j + 4'd1;
      end
      S_EXP_FIN: begin
        mant <= mul_p[61:30];
      end
      S_SCORE: begin
        score <= score_c;
        fi    <= 2'd0;
      end
      S_FN_E: begin
        ex      <= fn_v[15] ? $signed({1'b0, fq}) : -$signed({1'b0, fq});
        fn_mode <= 1'b1;
      end
      S_DIV_SETUP: begin
        // tanh uses twice the numerator of the sigmoid.
        rem      <= fi[1] ? (44'd1 << 42) : (44'd1 << 43);
        dd       <= (dw[61:44] != 18'd0) ? '1 : {dw[43:0], 13'd0};
        quo      <= '0;
        step_cnt <= 4'd13;
      end
      S_DIV: begin
        if (div_ge) begin
          rem <= rem - dd[43:0];
        end
        dd       <= dd >> 1;
        quo      <= quo_new;
        step_cnt <= step_cnt - 4'd1;
        if (step_cnt == 4'd0) begin
          unique case (fi)
            2'd0: tx <= $signed(quo_new) - 14'sd4096;
            2'd1: ty <= $signed(quo_new) - 14'sd4096;
            2'd2: sw <= quo_new[12:0];
            2'd3: sh <= quo_new[12:0];
          endcase
          fi <= fi + 2'd1;
          ci <= 2'd0;
        end
      end
      S_CRN_INIT: begin
        nneg <= num[22];
        nmag <= num[22] ? 21'(-num) : num[20:0];
      end
      S_CRN_Q: begin
        crn[ci] <= crn_c;
        ci      <= ci + 2'd1;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == S_EMIT) && (!res_valid || out_ch.ready)) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && (!res_valid || out_ch.ready)) begin
      out_ch.left_x          <= crn[0];
      out_ch.top_y           <= crn[1];
      out_ch.right_x         <= crn[2];
      out_ch.bottom_y        <= crn[3];
      out_ch.detection_score <= score;
      out_ch.class_id        <= best_class_index;
    end
  end

  assign out_ch.valid = res_valid;

endmodule
